// ----- hw/rtl/jac_pkg.sv -----
// Shared types, constants and tables for the joint angle calibrator.
`timescale 1ns / 1ps

package jac_pkg;

    // Table guide points by default
    localparam int TABLE_POINTS_DEF = 5;

    // Angle limits and fixed-point constants
    localparam int          ANGLE_MAX    = 18000;
    localparam logic [16:0] SCALE_ONE    = 17'd4096;
    localparam logic [16:0] SCALE_MAX    = 17'd131071;
    localparam logic [25:0] SCALE_NUM    = 26'd36864000;
    localparam int          CORDIC_STEPS = 18;
    localparam int          SQRT_STEPS   = 32;
    localparam int          DIV_STEPS    = 26;
    localparam int          MUL_STEPS    = 9;
    localparam logic signed [24:0] DEG90_Q8 = 25'sd2304000;

    // Configuration port
    localparam int               CFG_INDEX_W    = 2;
    localparam int               CFG_DATA_W     = 15;
    localparam logic [1:0]       CFG_MOUNT_FLIP = 2'd0;
    localparam logic [1:0]       CFG_MIN_SPAN   = 2'd1;
    localparam logic             MOUNT_FLIP_RST = 1'b1;
    localparam logic [14:0]      MIN_SPAN_RST   = 15'd500;

    typedef enum logic [2:0] {
        OP_MEASURE = 3'd0,
        OP_TABLE   = 3'd1,
        OP_HUMAN   = 3'd2,
        OP_CAPTURE = 3'd3,
        OP_QUIT    = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_MISSING   = 3'd1,
        ST_INACTIVE  = 3'd2,
        ST_SPAN      = 3'd3,
        ST_CAPTURED  = 3'd4,
        ST_COMPLETE  = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_MUL,
        BK_PREP,
        BK_SQR,
        BK_SQRT,
        BK_SETUP,
        BK_NORM,
        BK_ROT,
        BK_FIN,
        BK_DECIDE,
        BK_DIV,
        BK_CAL,
        BK_OUT
    } back_state_t;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [15:0] upper_x;
        logic signed [15:0] upper_y;
        logic signed [15:0] upper_z;
        logic signed [15:0] lower_x;
        logic signed [15:0] lower_y;
        logic signed [15:0] lower_z;
        logic               upper_valid;
        logic               lower_valid;
    } item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [14:0]        calibrated_angle;
        logic [14:0]        raw_angle;
        logic signed [15:0] capture_error;
        logic [2:0]         guide_step;
        logic               zero_captured;
    } result_t;

    // Classified request handed from the front to the back
    typedef struct packed {
        op_t                op;
        logic signed [16:0] ax;
        logic signed [16:0] ay;
        logic signed [16:0] az;
        logic signed [16:0] bx;
        logic signed [16:0] by;
        logic signed [16:0] bz;
        logic               ok;
        logic               skip;
    } work_t;

    // CORDIC rotation angles, 1/256 centidegree
    function automatic logic [20:0] atan_q8(input logic [4:0] i);
        logic [20:0] v;
        unique case (i)
            5'd0:  v = 21'd1152000;
            5'd1:  v = 21'd680065;
            5'd2:  v = 21'd359328;
            5'd3:  v = 21'd182400;
            5'd4:  v = 21'd91554;
            5'd5:  v = 21'd45822;
            5'd6:  v = 21'd22916;
            5'd7:  v = 21'd11459;
            5'd8:  v = 21'd5730;
            5'd9:  v = 21'd2865;
            5'd10: v = 21'd1432;
            5'd11: v = 21'd716;
            5'd12: v = 21'd358;
            5'd13: v = 21'd179;
            5'd14: v = 21'd90;
            5'd15: v = 21'd45;
            5'd16: v = 21'd22;
            5'd17: v = 21'd11;
            default: v = 21'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/jac_front.sv -----
// Front end: accepts requests, applies mount correction and classifies them.
`timescale 1ns / 1ps

module jac_front
    import jac_pkg::*;
(
    input  item_t item,
    input  logic  item_valid,
    output logic  item_ready,
    input  logic  mount_flip,
    input  logic  q_full,
    output logic  push,
    output work_t push_data
);

    logic ok;
    logic upper_zero;
    logic lower_zero;
    op_t  op;

    // Accept whenever the queue has room
    assign item_ready = !q_full;
    assign push       = item_valid && !q_full;

    // Detect missing sensors and zero vectors
    assign ok         = item.upper_valid && item.lower_valid;
    assign upper_zero = (item.upper_x == 16'sd0) && (item.upper_y == 16'sd0)
                        && (item.upper_z == 16'sd0);
    assign lower_zero = (item.lower_x == 16'sd0) && (item.lower_y == 16'sd0)
                        && (item.lower_z == 16'sd0);

    // Map unused operation codes onto measure
    always_comb
    begin
        unique case (item.operation)
            OP_TABLE:   op = OP_TABLE;
            OP_HUMAN:   op = OP_HUMAN;
            OP_CAPTURE: op = OP_CAPTURE;
            OP_QUIT:    op = OP_QUIT;
            default:    op = OP_MEASURE;
        endcase
    end

    // Build the work entry, negating lower y and z when mounted flipped
    always_comb
    begin
        push_data.op   = op;
        push_data.ax   = 17'(item.upper_x);
        push_data.ay   = 17'(item.upper_y);
        push_data.az   = 17'(item.upper_z);
        push_data.bx   = 17'(item.lower_x);
        push_data.by   = mount_flip ? -17'(item.lower_y) : 17'(item.lower_y);
        push_data.bz   = mount_flip ? -17'(item.lower_z) : 17'(item.lower_z);
        push_data.ok   = ok;
        push_data.skip = !ok || upper_zero || lower_zero;
    end

endmodule

// ----- hw/rtl/jac_queue.sv -----
// Two-entry queue between the front end and the compute back end.
`timescale 1ns / 1ps

module jac_queue
    import jac_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t push_data,
    output logic  full,
    input  logic  pop,
    output work_t pop_data,
    output logic  empty
);

    work_t      mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hw/rtl/jac_back.sv -----
// Back end: sequencer for vector angle, calibration state and result register.
`timescale 1ns / 1ps

module jac_back
    import jac_pkg::*;
#(
    parameter int TABLE_POINTS = TABLE_POINTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [14:0] min_span,
    input  logic        q_empty,
    input  work_t       q_data,
    output logic        q_pop,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result
);

    localparam int SW = $clog2(TABLE_POINTS + 1);
    localparam int TW = $clog2(TABLE_POINTS);
    localparam int GW = (SW > 3) ? SW : 3;

    // Evenly spaced table targets
    logic [14:0] target_tbl [TABLE_POINTS];
    for (genvar g = 0; g < TABLE_POINTS; g++)
    begin : g_target
        localparam int TGT = g * ANGLE_MAX / (TABLE_POINTS - 1);
        assign target_tbl[g] = 15'(TGT);
    end

    back_state_t state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    work_t       w_reg, w_next;

    logic signed [34:0] c0_reg, c0_next, c1_reg, c1_next, c2_reg, c2_next;
    logic signed [34:0] dot_reg, dot_next;
    logic [30:0]        cu0_reg, cu0_next, cu1_reg, cu1_next, cu2_reg, cu2_next;
    logic [62:0]        n_reg, n_next, res_reg, res_next, bit_reg, bit_next;
    logic signed [43:0] x_reg, x_next, y_reg, y_next;
    logic signed [24:0] z_reg, z_next;
    logic [14:0]        raw_reg, raw_next;
    logic [14:0]        cal_reg, cal_next;
    logic [14:0]        span_reg, span_next;
    logic [14:0]        target_reg, target_next;
    logic [25:0]        quo_reg, quo_next;
    logic [14:0]        rem_reg, rem_next;
    status_t            status_reg, status_next;
    logic               err_flag_reg, err_flag_next;

    logic [14:0]   zero_reg, zero_next;
    logic [16:0]   scale_reg, scale_next;
    logic          have_zero_reg, have_zero_next;
    logic          table_active_reg, table_active_next;
    logic          human_active_reg, human_active_next;
    logic [SW-1:0] tstep_reg, tstep_next;
    logic          hstep_reg, hstep_next;
    logic          result_valid_reg, result_valid_next;
    result_t       result_reg, result_next;

    // Datapath intermediates
    logic signed [16:0] mul_a, mul_b;
    logic signed [33:0] mul_p;
    logic signed [34:0] mul_ext;
    logic signed [34:0] a0, a1, a2;
    logic               big;
    logic [30:0]        sq_op;
    logic [61:0]        sq_p;
    logic [62:0]        trial;
    logic [43:0]        mag;
    logic signed [43:0] xs, ys;
    logic signed [24:0] atan_ext;
    logic signed [24:0] zr;
    logic signed [24:0] zs;
    logic [14:0]        diff;
    logic [31:0]        prod;
    logic [31:0]        cal_v;
    logic [14:0]        span_c;
    logic [15:0]        rem_sh;
    logic               ge;
    logic [25:0]        quo_fin;
    logic [SW-1:0]      tstep_inc;
    logic [GW-1:0]      tstep_ext;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Shared multiplier operand select for cross and dot products
    always_comb
    begin
        unique case (cnt_reg)
            5'd0:    begin mul_a = w_reg.ay; mul_b = w_reg.bz; end
            5'd1:    begin mul_a = w_reg.az; mul_b = w_reg.by; end
            5'd2:    begin mul_a = w_reg.az; mul_b = w_reg.bx; end
            5'd3:    begin mul_a = w_reg.ax; mul_b = w_reg.bz; end
            5'd4:    begin mul_a = w_reg.ax; mul_b = w_reg.by; end
            5'd5:    begin mul_a = w_reg.ay; mul_b = w_reg.bx; end
            5'd6:    begin mul_a = w_reg.ax; mul_b = w_reg.bx; end
            5'd7:    begin mul_a = w_reg.ay; mul_b = w_reg.by; end
            default: begin mul_a = w_reg.az; mul_b = w_reg.bz; end
        endcase
        mul_p   = mul_a * mul_b;
        mul_ext = {mul_p[33], mul_p};
    end

    // Fixed datapath pieces
    always_comb
    begin
        a0  = c0_reg[34] ? -c0_reg : c0_reg;
        a1  = c1_reg[34] ? -c1_reg : c1_reg;
        a2  = c2_reg[34] ? -c2_reg : c2_reg;
        big = (a0[34:30] != 5'd0) || (a1[34:30] != 5'd0) || (a2[34:30] != 5'd0);

        unique case (cnt_reg[1:0])
            2'd0:    sq_op = cu0_reg;
            2'd1:    sq_op = cu1_reg;
            default: sq_op = cu2_reg;
        endcase
        sq_p  = sq_op * sq_op;
        trial = res_reg + bit_reg;
        mag   = x_reg | y_reg;

        xs       = x_reg >>> cnt_reg;
        ys       = y_reg >>> cnt_reg;
        atan_ext = $signed({4'b0, atan_q8(cnt_reg)});
        zr       = z_reg + 25'sd128;
        zs       = zr >>> 8;

        diff   = (raw_reg > zero_reg) ? raw_reg - zero_reg : zero_reg - raw_reg;
        prod   = {17'b0, diff} * {15'b0, scale_reg};
        cal_v  = (prod + 32'd2048) >> 12;
        span_c = diff;

        rem_sh  = {rem_reg, quo_reg[25]};
        ge      = rem_sh >= {1'b0, span_reg};
        quo_fin = {quo_reg[24:0], ge};

        tstep_inc = tstep_reg + 1'b1;
        tstep_ext = GW'(tstep_reg);
    end

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        w_next            = w_reg;
        c0_next           = c0_reg;
        c1_next           = c1_reg;
        c2_next           = c2_reg;
        dot_next          = dot_reg;
        cu0_next          = cu0_reg;
        cu1_next          = cu1_reg;
        cu2_next          = cu2_reg;
        n_next            = n_reg;
        res_next          = res_reg;
        bit_next          = bit_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        z_next            = z_reg;
        raw_next          = raw_reg;
        cal_next          = cal_reg;
        span_next         = span_reg;
        target_next       = target_reg;
        quo_next          = quo_reg;
        rem_next          = rem_reg;
        status_next       = status_reg;
        err_flag_next     = err_flag_reg;
        zero_next         = zero_reg;
        scale_next        = scale_reg;
        have_zero_next    = have_zero_reg;
        table_active_next = table_active_reg;
        human_active_next = human_active_reg;
        tstep_next        = tstep_reg;
        hstep_next        = hstep_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        q_pop             = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                // Take the next request from the queue
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    w_next   = q_data;
                    cnt_next = 5'd0;
                    c0_next  = '0;
                    c1_next  = '0;
                    c2_next  = '0;
                    dot_next = '0;
                    raw_next = 15'd0;
                    state_next = q_data.skip ? BK_DECIDE : BK_MUL;
                end
            end
            BK_MUL:
            begin
                // Accumulate one product per cycle
                unique case (cnt_reg)
                    5'd0:    c0_next = c0_reg + mul_ext;
                    5'd1:    c0_next = c0_reg - mul_ext;
                    5'd2:    c1_next = c1_reg + mul_ext;
                    5'd3:    c1_next = c1_reg - mul_ext;
                    5'd4:    c2_next = c2_reg + mul_ext;
                    5'd5:    c2_next = c2_reg - mul_ext;
                    default: dot_next = dot_reg + mul_ext;
                endcase
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(MUL_STEPS - 1))
                begin
                    state_next = BK_PREP;
                end
            end
            BK_PREP:
            begin
                // Take magnitudes and halve everything if a cross term is large
                cu0_next = big ? a0[31:1] : a0[30:0];
                cu1_next = big ? a1[31:1] : a1[30:0];
                cu2_next = big ? a2[31:1] : a2[30:0];
                dot_next = big ? (dot_reg >>> 1) : dot_reg;
                n_next   = '0;
                cnt_next = 5'd0;
                state_next = BK_SQR;
            end
            BK_SQR:
            begin
                // Sum of squares of the cross product
                n_next   = n_reg + {1'b0, sq_p};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd2)
                begin
                    res_next   = '0;
                    bit_next   = {1'b1, 62'b0};
                    cnt_next   = 5'd0;
                    state_next = BK_SQRT;
                end
            end
            BK_SQRT:
            begin
                // One result bit per cycle
                if (n_reg >= trial)
                begin
                    n_next   = n_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(SQRT_STEPS - 1))
                begin
                    state_next = BK_SETUP;
                end
            end
            BK_SETUP:
            begin
                // Fold obtuse angles into the right half plane
                if (dot_reg[34])
                begin
                    x_next = $signed({13'b0, res_reg[30:0]});
                    y_next = 44'(-dot_reg);
                    z_next = DEG90_Q8;
                end
                else
                begin
                    x_next = 44'(dot_reg);
                    y_next = $signed({13'b0, res_reg[30:0]});
                    z_next = '0;
                end
                state_next = BK_NORM;
            end
            BK_NORM:
            begin
                // Shift operands up until the larger reaches 2^40
                if ((mag != 44'd0) && (mag[43:40] == 4'd0))
                begin
                    if (mag[39:32] == 8'd0)
                    begin
                        x_next = x_reg <<< 8;
                        y_next = y_reg <<< 8;
                    end
                    else
                    begin
                        x_next = x_reg <<< 1;
                        y_next = y_reg <<< 1;
                    end
                end
                else
                begin
                    cnt_next   = 5'd0;
                    state_next = BK_ROT;
                end
            end
            BK_ROT:
            begin
                // One CORDIC vectoring step per cycle
                if (!y_reg[43])
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + atan_ext;
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - atan_ext;
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(CORDIC_STEPS - 1))
                begin
                    state_next = BK_FIN;
                end
            end
            BK_FIN:
            begin
                // Round to centidegrees and clamp
                if (z_reg <= 25'sd0)
                begin
                    raw_next = 15'd0;
                end
                else if (zs > 25'sd18000)
                begin
                    raw_next = 15'(ANGLE_MAX);
                end
                else
                begin
                    raw_next = zs[14:0];
                end
                state_next = BK_DECIDE;
            end
            BK_DECIDE:
            begin
                // Apply the operation to the calibration state
                status_next   = ST_OK;
                err_flag_next = 1'b0;
                state_next    = BK_CAL;
                unique case (w_reg.op)
                    OP_TABLE:
                    begin
                        table_active_next = 1'b1;
                        human_active_next = 1'b0;
                        have_zero_next    = 1'b0;
                        tstep_next        = '0;
                        zero_next         = '0;
                        scale_next        = SCALE_ONE;
                    end
                    OP_HUMAN:
                    begin
                        human_active_next = 1'b1;
                        table_active_next = 1'b0;
                        have_zero_next    = 1'b0;
                        hstep_next        = 1'b0;
                        zero_next         = '0;
                        scale_next        = SCALE_ONE;
                    end
                    OP_QUIT:
                    begin
                        table_active_next = 1'b0;
                        human_active_next = 1'b0;
                    end
                    OP_CAPTURE:
                    begin
                        if (human_active_reg)
                        begin
                            if (!w_reg.ok)
                            begin
                                status_next = ST_MISSING;
                            end
                            else if (!hstep_reg)
                            begin
                                zero_next      = raw_reg;
                                scale_next     = SCALE_ONE;
                                have_zero_next = 1'b1;
                                hstep_next     = 1'b1;
                                status_next    = ST_CAPTURED;
                            end
                            else if ((span_c == 15'd0) || (span_c < min_span))
                            begin
                                status_next = ST_SPAN;
                            end
                            else
                            begin
                                human_active_next = 1'b0;
                                status_next       = ST_COMPLETE;
                                span_next         = span_c;
                                quo_next          = SCALE_NUM + 26'(span_c >> 1);
                                rem_next          = '0;
                                cnt_next          = 5'd0;
                                state_next        = BK_DIV;
                            end
                        end
                        else if (!table_active_reg)
                        begin
                            status_next = ST_INACTIVE;
                        end
                        else if (!w_reg.ok)
                        begin
                            status_next = ST_MISSING;
                        end
                        else
                        begin
                            if (tstep_reg == '0)
                            begin
                                zero_next      = raw_reg;
                                have_zero_next = 1'b1;
                            end
                            else
                            begin
                                err_flag_next = 1'b1;
                                target_next   = target_tbl[tstep_reg[TW-1:0]];
                            end
                            tstep_next = tstep_inc;
                            if (tstep_inc >= SW'(TABLE_POINTS))
                            begin
                                table_active_next = 1'b0;
                                status_next       = ST_COMPLETE;
                            end
                            else
                            begin
                                status_next = ST_CAPTURED;
                            end
                        end
                    end
                    default:
                    begin
                        status_next = w_reg.ok ? ST_OK : ST_MISSING;
                    end
                endcase
            end
            BK_DIV:
            begin
                // Restoring divide for the ninety-degree scale
                rem_next = ge ? 15'(rem_sh - {1'b0, span_reg}) : rem_sh[14:0];
                quo_next = quo_fin;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1))
                begin
                    scale_next = (quo_fin > 26'(SCALE_MAX)) ? SCALE_MAX : quo_fin[16:0];
                    state_next = BK_CAL;
                end
            end
            BK_CAL:
            begin
                // Scale the offset-corrected angle and saturate
                cal_next   = (cal_v > 32'(ANGLE_MAX)) ? 15'(ANGLE_MAX) : cal_v[14:0];
                state_next = BK_OUT;
            end
            BK_OUT:
            begin
                // Load the result register once it is free
                if (!result_valid_reg || result_ready)
                begin
                    result_next.status           = status_reg;
                    result_next.calibrated_angle = w_reg.ok ? cal_reg : 15'd0;
                    result_next.raw_angle        = raw_reg;
                    result_next.capture_error    = err_flag_reg
                        ? ($signed({1'b0, cal_reg}) - $signed({1'b0, target_reg}))
                        : 16'sd0;
                    result_next.guide_step       = (tstep_ext > GW'(7)) ? 3'd7
                                                                        : tstep_ext[2:0];
                    result_next.zero_captured    = have_zero_reg;
                    result_valid_next            = 1'b1;
                    state_next                   = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control and calibration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= BK_IDLE;
            cnt_reg          <= '0;
            zero_reg         <= '0;
            scale_reg        <= SCALE_ONE;
            have_zero_reg    <= 1'b0;
            table_active_reg <= 1'b0;
            human_active_reg <= 1'b0;
            tstep_reg        <= '0;
            hstep_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            zero_reg         <= zero_next;
            scale_reg        <= scale_next;
            have_zero_reg    <= have_zero_next;
            table_active_reg <= table_active_next;
            human_active_reg <= human_active_next;
            tstep_reg        <= tstep_next;
            hstep_reg        <= hstep_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        w_reg        <= w_next;
        c0_reg       <= c0_next;
        c1_reg       <= c1_next;
        c2_reg       <= c2_next;
        dot_reg      <= dot_next;
        cu0_reg      <= cu0_next;
        cu1_reg      <= cu1_next;
        cu2_reg      <= cu2_next;
        n_reg        <= n_next;
        res_reg      <= res_next;
        bit_reg      <= bit_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        z_reg        <= z_next;
        raw_reg      <= raw_next;
        cal_reg      <= cal_next;
        span_reg     <= span_next;
        target_reg   <= target_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        status_reg   <= status_next;
        err_flag_reg <= err_flag_next;
        result_reg   <= result_next;
    end

endmodule

// ----- hw/rtl/joint_angle_calibrator.sv -----
// Joint angle calibrator top level: config registers, front end, queue, back end.
// A request with a sensor missing or a zero vector skips the angle computation; a
// human span that sets the scale adds a restoring divide before the result.
// Requests are computed one at a time; the 32-step square root and the 18-step CORDIC
// run on one shared sequencer. A two-entry queue takes requests while it computes.
// Reset (rst_n low, asynchronous): queue empty, no result, mount_flip 1, min_span 500,
// zero offset 0, scale 1.0, both guides inactive, no zero captured.
`timescale 1ns / 1ps

module joint_angle_calibrator
    import jac_pkg::*;
#(
    parameter int TABLE_POINTS = TABLE_POINTS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  item_t                  item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_t                result
);

    logic        mount_flip_reg;
    logic        mount_flip_next;
    logic [14:0] min_span_reg;
    logic [14:0] min_span_next;
    logic        q_full;
    logic        q_empty;
    logic        push;
    logic        pop;
    work_t       push_data;
    work_t       pop_data;

    assign cfg_ready = 1'b1;

    // Decode configuration writes
    always_comb
    begin
        mount_flip_next = mount_flip_reg;
        min_span_next   = min_span_reg;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_MOUNT_FLIP)
            begin
                mount_flip_next = cfg_data[0];
            end
            else if (cfg_index == CFG_MIN_SPAN)
            begin
                min_span_next = cfg_data[14:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mount_flip_reg <= MOUNT_FLIP_RST;
            min_span_reg   <= MIN_SPAN_RST;
        end
        else
        begin
            mount_flip_reg <= mount_flip_next;
            min_span_reg   <= min_span_next;
        end
    end

    jac_front u_front (
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .mount_flip (mount_flip_reg),
        .q_full     (q_full),
        .push       (push),
        .push_data  (push_data)
    );

    jac_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    jac_back #(
        .TABLE_POINTS (TABLE_POINTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .min_span     (min_span_reg),
        .q_empty      (q_empty),
        .q_data       (pop_data),
        .q_pop        (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Angles stay within half a turn
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.raw_angle <= 15'(ANGLE_MAX))
                         && (result.calibrated_angle <= 15'(ANGLE_MAX)))
        else $error("angle out of range");

    // A capture or completion always leaves a zero offset behind
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && ((result.status == ST_CAPTURED) || (result.status == ST_COMPLETE))
        |-> result.zero_captured)
        else $error("capture without zero offset");

    // Capture error only appears on a successful table capture
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.capture_error != 16'sd0)
        |-> (result.status == ST_CAPTURED) || (result.status == ST_COMPLETE))
        else $error("capture error outside capture");

endmodule

// ----- tb/sv/jac_checker.sv -----
// Checker for the joint angle calibrator: predicts each result and compares it.
`timescale 1ns / 1ps

module jac_checker
    import jac_pkg::*;
#(
    parameter int TABLE_POINTS = TABLE_POINTS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   item_valid,
    input  logic                   item_ready,
    input  item_t                  item,
    input  logic                   result_valid,
    input  logic                   result_ready,
    input  result_t                result,
    output int                     errors,
    output int                     pending
);

    // CORDIC rotation angles in 1/256 centidegree
    localparam longint ROT_ANGLE [18] = '{
        1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459, 5730,
        2865, 1432, 716, 358, 179, 90, 45, 22, 11
    };

    // Configuration and calibration state
    logic        flip_lower;
    logic [14:0] span_floor;
    logic [14:0] zero_ofs;
    logic [16:0] scale_q12;
    logic        zero_held;
    logic        table_on;
    logic        human_on;
    logic [3:0]  table_idx;
    logic        human_idx;

    result_t expected_results[$];

    assign pending = expected_results.size();

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // Angle between two vectors in centidegrees, by CORDIC vectoring
    function automatic logic [14:0] joint_angle(input longint ax, ay, az, bx, by, bz);
        longint c0, c1, c2, dot, x, y, z, nx, ny;
        longint unsigned ux, uy, sq;
        if ((ax == 0 && ay == 0 && az == 0) || (bx == 0 && by == 0 && bz == 0))
            return 15'd0;
        c0 = ay * bz - az * by;
        c1 = az * bx - ax * bz;
        c2 = ax * by - ay * bx;
        if (c0 < 0) c0 = -c0;
        if (c1 < 0) c1 = -c1;
        if (c2 < 0) c2 = -c2;
        dot = ax * bx + ay * by + az * bz;
        if (c0 >= (64'sd1 <<< 30) || c1 >= (64'sd1 <<< 30) || c2 >= (64'sd1 <<< 30))
        begin
            c0 = c0 >>> 1;
            c1 = c1 >>> 1;
            c2 = c2 >>> 1;
            dot = dot >>> 1;
        end
        sq = c0 * c0 + c1 * c1 + c2 * c2;
        y = longint'(int_sqrt(sq));
        z = 0;
        if (dot < 0)
        begin
            x = y;
            y = -dot;
            z = 2304000;
        end
        else
            x = dot;
        ux = x;
        uy = y;
        if ((ux | uy) != 0)
            while ((ux | uy) < (64'd1 << 40))
            begin
                ux <<= 1;
                uy <<= 1;
            end
        x = ux;
        y = uy;
        for (int i = 0; i < 18; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += ROT_ANGLE[i];
            end
            else
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= ROT_ANGLE[i];
            end
            x = nx;
            y = ny;
        end
        if (z <= 0)
            return 15'd0;
        z = (z + 128) >>> 8;
        return (z > ANGLE_MAX) ? 15'(ANGLE_MAX) : 15'(z);
    endfunction

    function automatic logic [14:0] apply_scale(input logic [14:0] raw);
        longint unsigned d, v;
        d = (raw > zero_ofs) ? raw - zero_ofs : zero_ofs - raw;
        v = (d * scale_q12 + 2048) >> 12;
        return (v > ANGLE_MAX) ? 15'(ANGLE_MAX) : 15'(v);
    endfunction

    // Predict one result and advance the guide state
    function automatic result_t predict_angle(input item_t it);
        result_t r;
        logic ok;
        logic [14:0] raw, span;
        longint bx, by, bz, target, err;
        longint unsigned sc;
        ok = it.upper_valid && it.lower_valid;
        bx = it.lower_x;
        by = it.lower_y;
        bz = it.lower_z;
        if (flip_lower)
        begin
            by = -by;
            bz = -bz;
        end
        raw = ok ? joint_angle(it.upper_x, it.upper_y, it.upper_z, bx, by, bz) : 15'd0;
        err = 0;
        r.status = ST_OK;
        case (it.operation)
            OP_TABLE:
            begin
                table_on = 1'b1;
                human_on = 1'b0;
                zero_held = 1'b0;
                table_idx = 0;
                zero_ofs = 0;
                scale_q12 = SCALE_ONE;
            end
            OP_HUMAN:
            begin
                human_on = 1'b1;
                table_on = 1'b0;
                zero_held = 1'b0;
                human_idx = 1'b0;
                zero_ofs = 0;
                scale_q12 = SCALE_ONE;
            end
            OP_QUIT:
            begin
                table_on = 1'b0;
                human_on = 1'b0;
            end
            OP_CAPTURE:
            begin
                if (human_on)
                begin
                    if (!ok)
                        r.status = ST_MISSING;
                    else if (!human_idx)
                    begin
                        zero_ofs = raw;
                        scale_q12 = SCALE_ONE;
                        zero_held = 1'b1;
                        human_idx = 1'b1;
                        r.status = ST_CAPTURED;
                    end
                    else
                    begin
                        span = (raw > zero_ofs) ? raw - zero_ofs : zero_ofs - raw;
                        if (span == 0 || span < span_floor)
                            r.status = ST_SPAN;
                        else
                        begin
                            sc = (64'd36864000 + span / 2) / span;
                            scale_q12 = (sc > SCALE_MAX) ? SCALE_MAX : 17'(sc);
                            human_on = 1'b0;
                            r.status = ST_COMPLETE;
                        end
                    end
                end
                else if (!table_on)
                    r.status = ST_INACTIVE;
                else if (!ok)
                    r.status = ST_MISSING;
                else
                begin
                    if (table_idx == 0)
                    begin
                        zero_ofs = raw;
                        zero_held = 1'b1;
                    end
                    else
                    begin
                        target = longint'(table_idx) * ANGLE_MAX / (TABLE_POINTS - 1);
                        err = longint'(apply_scale(raw)) - target;
                    end
                    table_idx++;
                    if (table_idx >= TABLE_POINTS)
                    begin
                        table_on = 1'b0;
                        r.status = ST_COMPLETE;
                    end
                    else
                        r.status = ST_CAPTURED;
                end
            end
            default:
                r.status = ok ? ST_OK : ST_MISSING;
        endcase
        r.calibrated_angle = ok ? apply_scale(raw) : 15'd0;
        r.raw_angle = raw;
        r.capture_error = 16'(err);
        r.guide_step = (table_idx > 7) ? 3'd7 : table_idx[2:0];
        r.zero_captured = zero_held;
        return r;
    endfunction

    // Track registers, predict on each request, compare each result
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            flip_lower = MOUNT_FLIP_RST;
            span_floor = MIN_SPAN_RST;
            zero_ofs = 0;
            scale_q12 = SCALE_ONE;
            zero_held = 1'b0;
            table_on = 1'b0;
            human_on = 1'b0;
            table_idx = 0;
            human_idx = 1'b0;
            errors = 0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_MOUNT_FLIP)
                    flip_lower = cfg_data[0];
                else if (cfg_index == CFG_MIN_SPAN)
                    span_floor = cfg_data;
            end
            if (item_valid && item_ready)
                expected_results.push_back(predict_angle(item));
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, actual %p", $time, result);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result !== want)
                    begin
                        errors++;
                        $display("%0t: result mismatch, expected %p, actual %p",
                                 $time, want, result);
                    end
                end
            end
        end
    end

endmodule

// ----- tb/sv/tb.sv -----
// Testbench top: stimulus, receiver stalls, watchdog and verdict for the calibrator.
`timescale 1ns / 1ps

module tb;
    import jac_pkg::*;

    localparam int NUM_ITEMS  = 1950;
    localparam int IDLE_LIMIT = 20000;
    localparam int LONG_HOLD  = 600;
    localparam int DRAIN_WAIT = 200;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   item_valid = 1'b0;
    logic                   item_ready;
    item_t                  item = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    result_t                result;
    int                     errors;
    int                     pending;
    int                     sent = 0;
    logic                   quiet = 1'b0;
    int                     idle_cycles = 0;

    joint_angle_calibrator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    jac_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .errors       (errors),
        .pending      (pending)
    );

    always #1 clk = ~clk;

    // Abort when no handshake completes for too long
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off, none at the end
    initial
    begin
        int cycle_count;
        logic held;
        cycle_count = 0;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (quiet)
            begin
                result_ready <= 1'b1;
                @(posedge clk);
            end
            else if (!held && sent > 200)
            begin
                held = 1'b1;
                result_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                result_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // Offer one request and hold it until accepted
    task automatic send_request(input item_t it);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        sent++;
    endtask

    // Write one register once every expected result has drained
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [14:0] val);
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(0, 5))
            0, 1: return 16'($urandom_range(0, 65535));
            2:    return 16'($signed($urandom_range(0, 8000)) - 4000 + 16384);
            3:    return 16'(-16384 + $signed($urandom_range(0, 8000)) - 4000);
            4:    return 16'($signed($urandom_range(0, 6)) - 3);
            default: return 16'($signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    function automatic item_t make_item(input logic [2:0] op, input logic present);
        item_t it;
        it.operation = op;
        it.upper_x = rand_axis();
        it.upper_y = rand_axis();
        it.upper_z = rand_axis();
        it.lower_x = rand_axis();
        it.lower_y = rand_axis();
        it.lower_z = rand_axis();
        it.upper_valid = present || ($urandom_range(0, 1) == 1);
        it.lower_valid = present || ($urandom_range(0, 1) == 1);
        if ($urandom_range(0, 40) == 0)
            {it.upper_x, it.upper_y, it.upper_z} = '0;
        if ($urandom_range(0, 40) == 0)
            {it.lower_x, it.lower_y, it.lower_z} = '0;
        return it;
    endfunction

    function automatic item_t fixed_item(input logic [2:0] op,
                                         input logic [15:0] ux, uy, uz, lx, ly, lz,
                                         input logic uv, lv);
        item_t it;
        it.operation = op;
        it.upper_x = ux;
        it.upper_y = uy;
        it.upper_z = uz;
        it.lower_x = lx;
        it.lower_y = ly;
        it.lower_z = lz;
        it.upper_valid = uv;
        it.lower_valid = lv;
        return it;
    endfunction

    // Random guide sequence, mostly well formed
    task automatic random_sequence();
        int n;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                send_request(make_item(OP_TABLE, 1'b1));
                n = $urandom_range(3, 6);
                for (int i = 0; i < n; i++)
                    send_request(make_item(($urandom_range(0, 9) == 0) ? OP_MEASURE
                                           : OP_CAPTURE, $urandom_range(0, 9) != 0));
            end
            3, 4, 5:
            begin
                send_request(make_item(OP_HUMAN, 1'b1));
                n = $urandom_range(2, 4);
                for (int i = 0; i < n; i++)
                    send_request(make_item(OP_CAPTURE, $urandom_range(0, 9) != 0));
                send_request(make_item(OP_MEASURE, 1'b1));
            end
            6, 7:
                send_request(make_item(OP_MEASURE, $urandom_range(0, 5) != 0));
            default:
                send_request(make_item(3'($urandom_range(0, 7)), 1'b0));
        endcase
    endtask

    // Stimulus and verdict
    initial
    begin
        int phase;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes and special cases
        send_request(fixed_item(OP_MEASURE, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                16'h8000, 16'h8000, 16'h8000, 1, 1));
        send_request(fixed_item(OP_MEASURE, 16'h8000, 16'h8000, 16'h8000,
                                16'h8000, 16'h8000, 16'h8000, 1, 1));
        send_request(fixed_item(OP_MEASURE, 16'h7FFF, 16'h8000, 16'h7FFF,
                                16'h8000, 16'h7FFF, 16'h8000, 1, 1));
        send_request(fixed_item(OP_MEASURE, 0, 0, 0, 100, 0, 0, 1, 1));
        send_request(fixed_item(OP_MEASURE, 100, 0, 0, 100, 0, 0, 0, 1));
        send_request(fixed_item(OP_MEASURE, 100, 0, 0, 100, 0, 0, 1, 0));
        send_request(fixed_item(3'd5, 100, 0, 0, 0, 100, 0, 1, 1));
        send_request(fixed_item(3'd6, 100, 0, 0, 0, 100, 0, 1, 1));
        send_request(fixed_item(3'd7, 100, 0, 0, 0, 100, 0, 1, 1));
        send_request(fixed_item(OP_CAPTURE, 100, 0, 0, 0, 100, 0, 1, 1));
        send_request(fixed_item(OP_TABLE, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(fixed_item(OP_CAPTURE, 100, 0, 0, 100, 0, 0, 1, 0));
        send_request(fixed_item(OP_CAPTURE, 0, 0, 16384, 0, 0, -16384, 1, 1));
        send_request(fixed_item(OP_CAPTURE, 0, 0, 16384, 11585, 0, -11585, 1, 1));
        send_request(fixed_item(OP_CAPTURE, 0, 0, 16384, 16384, 0, 0, 1, 1));
        send_request(fixed_item(OP_CAPTURE, 0, 0, 16384, 11585, 0, 11585, 1, 1));
        send_request(fixed_item(OP_CAPTURE, 0, 0, 16384, 0, 0, 16384, 1, 1));
        send_request(fixed_item(OP_HUMAN, 0, 0, 0, 0, 0, 0, 1, 1));
        send_request(fixed_item(OP_CAPTURE, 0, 0, 16384, 0, 0, -16384, 0, 1));
        send_request(fixed_item(OP_CAPTURE, 0, 0, 16384, 0, 0, -16384, 1, 1));
        send_request(fixed_item(OP_CAPTURE, 0, 0, 16384, 0, 0, -16384, 1, 1));
        send_request(fixed_item(OP_CAPTURE, 0, 0, 16384, 100, 0, -16384, 1, 1));
        send_request(fixed_item(OP_CAPTURE, 0, 0, 16384, 16384, 0, 0, 1, 1));
        send_request(fixed_item(OP_MEASURE, 0, 0, 16384, 16384, 0, 16384, 1, 1));
        send_request(fixed_item(OP_QUIT, 0, 0, 0, 0, 0, 0, 1, 1));

        // Random part across register settings
        phase = 0;
        while (sent < NUM_ITEMS)
        begin
            if (sent >= 300 * (phase + 1) && phase < 5)
            begin
                phase++;
                case (phase)
                    1: begin write_reg(CFG_MOUNT_FLIP, 15'd0); write_reg(CFG_MIN_SPAN, 15'd0); end
                    2: write_reg(CFG_MIN_SPAN, 15'd18000);
                    3: begin write_reg(CFG_MOUNT_FLIP, 15'd1); write_reg(CFG_MIN_SPAN, 15'h7FFF); end
                    4: write_reg(CFG_MIN_SPAN, 15'($urandom_range(0, 3000)));
                    default: write_reg(CFG_MIN_SPAN, 15'd500);
                endcase
            end
            if (NUM_ITEMS - sent < 150)
                quiet <= 1'b1;
            random_sequence();
        end
        item_valid <= 1'b0;

        // Drain and settle
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
